// ===== rtl/core/fcc_pkg.sv =====
// Shared types and constants for the floor climb counter.
// Holds the beat structs of both channels, register indexes and the divider result.
// No dependencies.
package fcc_pkg;

	localparam int ALT_W  = 21;
	localparam int DAY_W  = 9;
	localparam int REG_W  = 10;
	localparam int IDX_W  = 2;
	// Accumulator width during the floor division: the remainder plus a full altitude swing.
	localparam int PROG_W = 22;
	localparam int OUT_W  = 16;

	localparam logic [IDX_W-1:0] REG_FLOOR_HEIGHT = 2'd0;
	localparam logic [IDX_W-1:0] REG_HYSTERESIS   = 2'd1;

	localparam logic [REG_W-1:0] FLOOR_HEIGHT_RST = 10'd300;
	localparam logic [REG_W-1:0] HYSTERESIS_RST   = 10'd50;
	localparam logic [DAY_W-1:0] DAY_UNSET        = 9'd511;

	typedef struct packed {
		logic signed [ALT_W-1:0] altitude_cm;
		logic [DAY_W-1:0]        day_of_year;
	} sample_t;

	typedef struct packed {
		logic [OUT_W-1:0] up_total;
		logic [OUT_W-1:0] down_total;
	} result_t;

	typedef struct packed {
		logic              done;
		logic [PROG_W-1:0] quotient;
		logic [REG_W-1:0]  remainder;
	} div_res_t;

endpackage

// ===== rtl/core/fcc_div.sv =====
// Restoring divider shared by both accumulators of the floor climb counter.
// One quotient bit per cycle; depends on fcc_pkg.
module fcc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [fcc_pkg::PROG_W-1:0] dividend,
	input  logic [fcc_pkg::REG_W-1:0]  divisor,
	output fcc_pkg::div_res_t          res
);

	localparam int CNT_W = $clog2(fcc_pkg::PROG_W);

	logic [fcc_pkg::PROG_W-1:0] num_q;
	logic [fcc_pkg::REG_W-1:0]  rem_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [fcc_pkg::REG_W:0] trial;
	logic [fcc_pkg::REG_W:0] diff;
	logic                    qbit;

	always_comb begin
		trial = {rem_q, num_q[fcc_pkg::PROG_W-1]};
		diff  = trial - {1'b0, divisor};
		qbit  = (trial >= {1'b0, divisor});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(fcc_pkg::PROG_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// The dividend shifts out at the top while quotient bits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[fcc_pkg::PROG_W-2:0], qbit};
			rem_q <= qbit ? diff[fcc_pkg::REG_W-1:0] : trial[fcc_pkg::REG_W-1:0];
		end
	end

	assign res.done      = done_q;
	assign res.quotient  = num_q;
	assign res.remainder = rem_q;

endmodule

// ===== rtl/core/floor_climb_counter_core.sv =====
// Barometric floor counter with hysteresis and a daily reset of the counts.
// The first sample after reset only records the altitude and goes straight to emission; every
// later sample takes two passes of the 22-step shared divider, one for climb, one for descent.
// One sample at a time; the sample channel stalls until the result is registered.
// Reset clears all counts and the climb and descent remainders, marks the day as unset and loads default registers.
module floor_climb_counter_core #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [fcc_pkg::IDX_W-1:0] cfg_index,
	input  logic [fcc_pkg::REG_W-1:0] cfg_wdata,
	input  logic                      sample_valid,
	output logic                      sample_stall,
	input  fcc_pkg::sample_t          sample,
	output logic                      result_valid,
	input  logic                      result_stall,
	output fcc_pkg::result_t          result
);

	localparam int SUM_W = COUNT_WIDTH + fcc_pkg::PROG_W;
	localparam int EXT_W = COUNT_WIDTH + fcc_pkg::OUT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_UP,
		ST_DIV_DN,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [fcc_pkg::REG_W-1:0]        floor_height_q;
	logic [fcc_pkg::REG_W-1:0]        hysteresis_q;
	logic signed [fcc_pkg::ALT_W-1:0] prev_alt_q;
	logic                             have_prev_q;
	logic [fcc_pkg::REG_W-1:0]        climb_q;
	logic [fcc_pkg::REG_W-1:0]        descent_q;
	logic [fcc_pkg::PROG_W-1:0]       climb_acc_q;
	logic [fcc_pkg::PROG_W-1:0]       descent_acc_q;
	logic [COUNT_WIDTH-1:0]           up_q;
	logic [COUNT_WIDTH-1:0]           down_q;
	logic [fcc_pkg::DAY_W-1:0]        day_q;
	logic                             div_start_q;
	logic                             result_valid_q;
	fcc_pkg::result_t                 result_q;

	logic                         accept;
	logic                         new_day;
	logic [fcc_pkg::REG_W-1:0]    climb_base;
	logic [fcc_pkg::REG_W-1:0]    descent_base;
	logic [fcc_pkg::ALT_W:0]      delta;
	logic [fcc_pkg::ALT_W:0]      delta_abs;
	logic [fcc_pkg::ALT_W-1:0]    mag;
	logic                         rising;
	logic                         falling;
	logic                         big_move;
	logic [fcc_pkg::PROG_W-1:0]   climb_next;
	logic [fcc_pkg::PROG_W-1:0]   descent_next;
	logic [fcc_pkg::REG_W-1:0]    floor_div;
	logic [fcc_pkg::PROG_W-1:0]   div_operand;
	fcc_pkg::div_res_t            div_res;
	logic [SUM_W-1:0]             up_sum;
	logic [SUM_W-1:0]             down_sum;
	logic [EXT_W-1:0]             up_ext;
	logic [EXT_W-1:0]             down_ext;
	logic                         out_free;

	assign accept       = sample_valid && !sample_stall;
	assign sample_stall = (state_q != ST_IDLE);
	assign out_free     = !result_valid_q || !result_stall;

	always_comb begin
		new_day      = (sample.day_of_year != day_q);
		climb_base   = new_day ? '0 : climb_q;
		descent_base = new_day ? '0 : descent_q;
		delta        = {sample.altitude_cm[fcc_pkg::ALT_W-1], sample.altitude_cm}
		             - {prev_alt_q[fcc_pkg::ALT_W-1], prev_alt_q};
		falling      = delta[fcc_pkg::ALT_W];
		rising       = !falling && (delta != '0);
		delta_abs    = falling ? (~delta + 1'b1) : delta;
		mag          = delta_abs[fcc_pkg::ALT_W-1:0];
		big_move     = (mag > fcc_pkg::ALT_W'(hysteresis_q));
		climb_next   = fcc_pkg::PROG_W'(climb_base);
		descent_next = fcc_pkg::PROG_W'(descent_base);
		// A rise grows the climb and eats into the descent; a fall is the mirror case.
		if (rising) begin
			climb_next = fcc_pkg::PROG_W'(climb_base) + fcc_pkg::PROG_W'(mag);
			if (big_move || (fcc_pkg::ALT_W'(descent_base) <= mag)) begin
				descent_next = '0;
			end else begin
				descent_next = fcc_pkg::PROG_W'(fcc_pkg::ALT_W'(descent_base) - mag);
			end
		end else if (falling) begin
			descent_next = fcc_pkg::PROG_W'(descent_base) + fcc_pkg::PROG_W'(mag);
			if (big_move || (fcc_pkg::ALT_W'(climb_base) <= mag)) begin
				climb_next = '0;
			end else begin
				climb_next = fcc_pkg::PROG_W'(fcc_pkg::ALT_W'(climb_base) - mag);
			end
		end
	end

	assign floor_div   = (floor_height_q == '0) ? fcc_pkg::REG_W'(1) : floor_height_q;
	assign div_operand = (state_q == ST_DIV_UP) ? climb_acc_q : descent_acc_q;

	fcc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_operand),
		.divisor  (floor_div),
		.res      (div_res)
	);

	assign up_sum   = SUM_W'(up_q) + SUM_W'(div_res.quotient);
	assign down_sum = SUM_W'(down_q) + SUM_W'(div_res.quotient);
	assign up_ext   = EXT_W'(up_q);
	assign down_ext = EXT_W'(down_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_height_q <= fcc_pkg::FLOOR_HEIGHT_RST;
			hysteresis_q   <= fcc_pkg::HYSTERESIS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fcc_pkg::REG_FLOOR_HEIGHT: floor_height_q <= cfg_wdata;
				fcc_pkg::REG_HYSTERESIS:   hysteresis_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			prev_alt_q     <= '0;
			have_prev_q    <= 1'b0;
			climb_q        <= '0;
			descent_q      <= '0;
			up_q           <= '0;
			down_q         <= '0;
			day_q          <= fcc_pkg::DAY_UNSET;
			div_start_q    <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			// The divider starts once for the climb and once more for the descent.
			div_start_q <= ((state_q == ST_IDLE) && accept && have_prev_q)
			            || ((state_q == ST_DIV_UP) && div_res.done);
			if ((state_q == ST_EMIT) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						day_q      <= sample.day_of_year;
						prev_alt_q <= sample.altitude_cm;
						if (new_day) begin
							up_q      <= '0;
							down_q    <= '0;
							climb_q   <= '0;
							descent_q <= '0;
						end
						if (!have_prev_q) begin
							have_prev_q <= 1'b1;
							state_q     <= ST_EMIT;
						end else begin
							state_q     <= ST_DIV_UP;
						end
					end
				end
				ST_DIV_UP: begin
					if (div_res.done) begin
						up_q    <= up_sum[COUNT_WIDTH-1:0];
						climb_q <= div_res.remainder;
						state_q <= ST_DIV_DN;
					end
				end
				ST_DIV_DN: begin
					if (div_res.done) begin
						down_q    <= down_sum[COUNT_WIDTH-1:0];
						descent_q <= div_res.remainder;
						state_q   <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			climb_acc_q   <= climb_next;
			descent_acc_q <= descent_next;
		end
		if ((state_q == ST_EMIT) && out_free) begin
			result_q.up_total   <= up_ext[fcc_pkg::OUT_W-1:0];
			result_q.down_total <= down_ext[fcc_pkg::OUT_W-1:0];
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
